// ===== sv/tpr_pkg.sv =====
// Shared types and constants for the triangle pair request and check unit.
// No dependencies; used by tpr_ctrl, tpr_datapath and the top level.
package tpr_pkg;

  localparam int MAX_NEIGHBORS = 1024;
  localparam int ADDR_W        = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W         = ADDR_W + 1;   // holds 0..MAX_NEIGHBORS
  localparam int CJ_W          = CNT_W + 1;    // holds up to MAX_NEIGHBORS + 2
  localparam int QUOTA_W       = 8;
  localparam int DEGREE_W      = 20;
  localparam int PAIRS_W       = 28;
  localparam int ID_W          = 31;
  localparam int KEY_W         = 20;
  localparam int HITS_W        = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [QUOTA_W-1:0]   QUOTA_RESET = QUOTA_W'(10);
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_CHECK = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [ID_W-1:0]    edge_id;
    logic [KEY_W-1:0]   edge_key;
  } in_item_t;

  typedef struct packed {
    logic [PAIRS_W-1:0] pair_count;
    logic               halted;
    logic [ID_W-1:0]    dest_id;
    logic [ID_W-1:0]    pair_edge_id;
    logic [KEY_W-1:0]   pair_edge_key;
    logic               last_pair;
    logic               found;
    logic [HITS_W-1:0]  triangle_count;
    logic               table_full;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_RND_INIT,
    OP_RND_STEP,
    OP_RND_FIN,
    OP_RD_I,
    OP_RD_J,
    OP_FETCH_FIN,
    OP_CHK_INIT,
    OP_CHK_RD,
    OP_CHK_CMP,
    OP_CHK_FRD,
    OP_CHK_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    rnd_done;
    logic    chk_open;
    logic    pairs_zero;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_RND_STEP,
    ST_RND_FIN,
    ST_RD_I,
    ST_RD_J,
    ST_FETCH_FIN,
    ST_CHK_LOOP,
    ST_CHK_CMP,
    ST_CHK_FRD,
    ST_CHK_FIN
  } state_t;

endpackage

// ===== sv/tpr_ctrl.sv =====
// Sequencer for the triangle pair unit: accepts items, steps the datapath,
// owns the output valid flag. Depends on tpr_pkg.
module tpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tpr_pkg::dp_status_t status,
  output tpr_pkg::dp_cmd_t    cmd
);

  tpr_pkg::state_t state, state_next;
  logic            out_free;
  logic            finish;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = tpr_pkg::OP_NONE;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      tpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = tpr_pkg::OP_LATCH;
          state_next = tpr_pkg::ST_DISPATCH;
        end
      end
      tpr_pkg::ST_DISPATCH: begin
        unique case (status.action)
          tpr_pkg::ACT_LOAD:  state_next = tpr_pkg::ST_LOAD;
          tpr_pkg::ACT_BEGIN: begin
            cmd.op     = tpr_pkg::OP_RND_INIT;
            state_next = tpr_pkg::ST_RND_STEP;
          end
          tpr_pkg::ACT_FETCH: begin
            state_next = status.pairs_zero ? tpr_pkg::ST_FETCH_FIN : tpr_pkg::ST_RD_I;
          end
          tpr_pkg::ACT_CHECK: begin
            cmd.op     = tpr_pkg::OP_CHK_INIT;
            state_next = tpr_pkg::ST_CHK_LOOP;
          end
          default: state_next = tpr_pkg::ST_IDLE;
        endcase
      end
      tpr_pkg::ST_LOAD: begin
        if (out_free) begin
          cmd.op     = tpr_pkg::OP_LOAD;
          finish     = 1'b1;
          state_next = tpr_pkg::ST_IDLE;
        end
      end
      tpr_pkg::ST_RND_STEP: begin
        if (status.rnd_done) begin
          state_next = tpr_pkg::ST_RND_FIN;
        end else begin
          cmd.op = tpr_pkg::OP_RND_STEP;
        end
      end
      tpr_pkg::ST_RND_FIN: begin
        if (out_free) begin
          cmd.op     = tpr_pkg::OP_RND_FIN;
          finish     = 1'b1;
          state_next = tpr_pkg::ST_IDLE;
        end
      end
      tpr_pkg::ST_RD_I: begin
        cmd.op     = tpr_pkg::OP_RD_I;
        state_next = tpr_pkg::ST_RD_J;
      end
      tpr_pkg::ST_RD_J: begin
        cmd.op     = tpr_pkg::OP_RD_J;
        state_next = tpr_pkg::ST_FETCH_FIN;
      end
      tpr_pkg::ST_FETCH_FIN: begin
        if (out_free) begin
          cmd.op     = tpr_pkg::OP_FETCH_FIN;
          finish     = 1'b1;
          state_next = tpr_pkg::ST_IDLE;
        end
      end
      tpr_pkg::ST_CHK_LOOP: begin
        if (status.chk_open) begin
          cmd.op     = tpr_pkg::OP_CHK_RD;
          state_next = tpr_pkg::ST_CHK_CMP;
        end else begin
          state_next = tpr_pkg::ST_CHK_FRD;
        end
      end
      tpr_pkg::ST_CHK_CMP: begin
        cmd.op     = tpr_pkg::OP_CHK_CMP;
        state_next = tpr_pkg::ST_CHK_LOOP;
      end
      tpr_pkg::ST_CHK_FRD: begin
        cmd.op     = tpr_pkg::OP_CHK_FRD;
        state_next = tpr_pkg::ST_CHK_FIN;
      end
      tpr_pkg::ST_CHK_FIN: begin
        if (out_free) begin
          cmd.op     = tpr_pkg::OP_CHK_FIN;
          finish     = 1'b1;
          state_next = tpr_pkg::ST_IDLE;
        end
      end
      default: state_next = tpr_pkg::ST_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !finish && cmd.op != tpr_pkg::OP_RND_STEP)
    else $error("input taken while work in progress");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished result not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

endmodule

// ===== sv/tpr_datapath.sv =====
// Datapath: neighbor tables, pair cursor walk, binary search, result register,
// configuration registers. Depends on tpr_pkg; driven by tpr_ctrl commands.
module tpr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tpr_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpr_pkg::DEGREE_W-1:0]        cfg_data,
  input  tpr_pkg::dp_cmd_t                    cmd,
  output tpr_pkg::dp_status_t                 status,
  output tpr_pkg::out_item_t                  res
);

  localparam int AW  = tpr_pkg::ADDR_W;
  localparam int CW  = tpr_pkg::CNT_W;
  localparam int JW  = tpr_pkg::CJ_W;
  localparam int PW  = tpr_pkg::PAIRS_W;

  logic [tpr_pkg::ID_W-1:0]  id_mem  [tpr_pkg::MAX_NEIGHBORS];
  logic [tpr_pkg::KEY_W-1:0] key_mem [tpr_pkg::MAX_NEIGHBORS];

  tpr_pkg::in_item_t            req;
  logic [tpr_pkg::QUOTA_W-1:0]  quota_factor;
  logic [tpr_pkg::DEGREE_W-1:0] vertex_degree;
  logic [CW-1:0]                entry_count;
  logic [CW-1:0]                cursor_i;
  logic [JW-1:0]                cursor_j;
  logic [CW-1:0]                emit_i;
  logic [CW-1:0]                emit_j;
  logic [PW-1:0]                pairs_left;
  logic [tpr_pkg::HITS_W-1:0]   hit_count;

  // round walk
  logic [CW-1:0] bi;
  logic [JW-1:0] bj;
  logic [PW-1:0] quota;
  logic [PW-1:0] cnt;
  logic          quota_pos;

  // search
  logic [CW-1:0] lo, hi, mid;

  logic [tpr_pkg::ID_W-1:0]  id_rd, dest;
  logic [tpr_pkg::KEY_W-1:0] key_rd;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      do_write;

  logic [JW-1:0] len_j;
  logic [CW-1:0] avail;
  logic [PW-1:0] quota_init;
  logic          key_lt;
  logic [PW-1:0] pl_dec;
  logic [CW-1:0] jd;
  logic [CW-1:0] fin_ei, fin_ej;
  logic [JW-1:0] bj_sat;

  assign len_j      = JW'(entry_count);
  assign avail      = (bj < len_j) ? CW'(len_j - bj) : '0;
  assign quota_init = PW'(quota_factor) * PW'(vertex_degree);
  assign mid        = lo + ((hi - lo) >> 1);
  assign key_lt     = (key_rd < req.edge_key) ||
                      (key_rd == req.edge_key && id_rd < req.edge_id);
  assign pl_dec     = pairs_left - PW'(1);
  assign jd         = emit_j - CW'(1);
  assign do_write   = cmd.op == tpr_pkg::OP_LOAD && pairs_left == '0 &&
                      entry_count < CW'(tpr_pkg::MAX_NEIGHBORS);
  assign bj_sat     = (bj > JW'(tpr_pkg::MAX_NEIGHBORS + 1)) ?
                      JW'(tpr_pkg::MAX_NEIGHBORS + 1) : bj;

  always_comb begin
    if (bj >= len_j) begin
      fin_ej = entry_count - CW'(1);
      fin_ei = entry_count - CW'(2);
    end else begin
      fin_ej = CW'(bj);
      fin_ei = bi;
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (cmd.op)
      tpr_pkg::OP_RD_I:    rd_addr = emit_i[AW-1:0];
      tpr_pkg::OP_RD_J:    rd_addr = emit_j[AW-1:0];
      tpr_pkg::OP_CHK_RD:  rd_addr = mid[AW-1:0];
      tpr_pkg::OP_CHK_FRD: rd_addr = lo[AW-1:0];
      default:             rd_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      id_mem[entry_count[AW-1:0]]  <= req.edge_id;
      key_mem[entry_count[AW-1:0]] <= req.edge_key;
    end
    if (rd_en) begin
      id_rd  <= id_mem[rd_addr];
      key_rd <= key_mem[rd_addr];
    end
  end

  assign status.action     = req.action;
  assign status.rnd_done   = (quota == '0) || (bi >= entry_count);
  assign status.chk_open   = lo < hi;
  assign status.pairs_zero = pairs_left == '0;

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tpr_pkg::OP_LATCH:    req <= in_data;
      tpr_pkg::OP_RND_INIT: begin
        bi        <= cursor_i;
        bj        <= cursor_j + JW'(1);
        quota     <= quota_init;
        quota_pos <= quota_init != '0;
        cnt       <= '0;
      end
      tpr_pkg::OP_RND_STEP: begin
        if (PW'(avail) >= quota) begin
          bj    <= bj + JW'(quota) - JW'(1);
          cnt   <= cnt + quota;
          quota <= '0;
        end else begin
          cnt   <= cnt + PW'(avail);
          quota <= quota - PW'(avail);
          bj    <= JW'(bi) + JW'(2);
          bi    <= bi + CW'(1);
        end
      end
      tpr_pkg::OP_RD_J:     dest <= id_rd;
      tpr_pkg::OP_CHK_INIT: begin
        lo <= '0;
        hi <= entry_count;
      end
      tpr_pkg::OP_CHK_CMP: begin
        if (key_lt) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      default: ;
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quota_factor  <= tpr_pkg::QUOTA_RESET;
      vertex_degree <= '0;
      entry_count   <= '0;
      cursor_i      <= '0;
      cursor_j      <= '0;
      emit_i        <= '0;
      emit_j        <= '0;
      pairs_left    <= '0;
      hit_count     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tpr_pkg::CFG_QUOTA:  quota_factor  <= cfg_data[tpr_pkg::QUOTA_W-1:0];
          tpr_pkg::CFG_DEGREE: vertex_degree <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        tpr_pkg::OP_LOAD: begin
          if (do_write) begin
            entry_count <= entry_count + CW'(1);
          end
        end
        tpr_pkg::OP_RND_FIN: begin
          if (quota_pos) begin
            cursor_i <= bi;
            cursor_j <= bj_sat;
          end
          pairs_left <= cnt;
          if (cnt != '0) begin
            emit_i <= fin_ei;
            emit_j <= fin_ej;
          end else begin
            emit_i <= '0;
            emit_j <= '0;
          end
        end
        tpr_pkg::OP_FETCH_FIN: begin
          if (pairs_left != '0) begin
            pairs_left <= pl_dec;
            if (pl_dec != '0) begin
              if (jd <= emit_i) begin
                emit_i <= emit_i - CW'(1);
                emit_j <= entry_count - CW'(1);
              end else begin
                emit_j <= jd;
              end
            end
          end
        end
        tpr_pkg::OP_CHK_FIN: begin
          if (lo < entry_count && key_rd == req.edge_key && id_rd == req.edge_id &&
              hit_count != '1) begin
            hit_count <= hit_count + tpr_pkg::HITS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  logic hit;
  assign hit = lo < entry_count && key_rd == req.edge_key && id_rd == req.edge_id;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tpr_pkg::OP_LOAD: begin
        res                <= '0;
        res.triangle_count <= hit_count;
        res.table_full     <= pairs_left == '0 && !do_write;
      end
      tpr_pkg::OP_RND_FIN: begin
        res                <= '0;
        res.pair_count     <= cnt;
        res.halted         <= cnt == '0;
        res.triangle_count <= hit_count;
      end
      tpr_pkg::OP_FETCH_FIN: begin
        res                <= '0;
        res.triangle_count <= hit_count;
        if (pairs_left != '0) begin
          res.dest_id       <= dest;
          res.pair_edge_id  <= id_rd;
          res.pair_edge_key <= key_rd;
          res.last_pair     <= pl_dec == '0;
        end
      end
      tpr_pkg::OP_CHK_FIN: begin
        res                <= '0;
        res.found          <= hit;
        res.triangle_count <= (hit && hit_count != '1) ?
                              hit_count + tpr_pkg::HITS_W'(1) : hit_count;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(tpr_pkg::MAX_NEIGHBORS))
    else $error("entry count past table size");
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_j <= JW'(tpr_pkg::MAX_NEIGHBORS + 1))
    else $error("cursor_j past saturation");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    pairs_left != '0 |-> emit_i < emit_j && emit_j < entry_count)
    else $error("pending pair outside table");

endmodule

// ===== sv/triangle_pair_request_and_check_unit.sv =====
// Top level of the triangle pair request and check unit.
// Depends on tpr_pkg, tpr_ctrl and tpr_datapath.
//
// Channels: in_valid/in_ready/in_data carries one item (load, begin round,
// fetch pair, check edge); out_valid/out_ready/out_data returns exactly one
// result per item, in order. cfg_valid/cfg_index/cfg_data writes quota_factor
// (index 0) or vertex_degree (index 1); cfg_ready is always high.
// One item is worked on at a time; in_ready is high only when the sequencer
// is idle. A begin round walks the cursor one row per cycle (each table row
// crossed, plus one step when the quota runs out inside a row; at most entry
// count steps), and a check edge item runs a binary search over the
// single-port neighbor tables.
// The result sits in an output register; the next item is taken while it
// waits, and only its own result waits for out_ready. A stalled receiver
// therefore holds back at most one further item.
// Reset (rst, synchronous) empties the table, clears cursors, pending pairs
// and the triangle count, and sets quota_factor to 10, vertex_degree to 0.
module triangle_pair_request_and_check_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tpr_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpr_pkg::DEGREE_W-1:0]  cfg_data
);

  tpr_pkg::dp_cmd_t    cmd;
  tpr_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tpr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .res       (out_data)
  );

endmodule

// ===== tb/triangle_pair_request_and_check_unit_tb.sv =====
// Testbench for triangle_pair_request_and_check_unit: directed table, then random phases.
// Depends on tpr_pkg; results are checked in order against a predictor of the block.
module triangle_pair_request_and_check_unit_tb;

  localparam int WATCH_LIMIT = 20000;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t                            kind;
    tpr_pkg::in_item_t                    item;
    bit                                   typed;
    tpr_pkg::out_item_t                   want;
    logic [tpr_pkg::CFG_IDX_W-1:0]        idx;
    logic [tpr_pkg::DEGREE_W-1:0]         data;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  tpr_pkg::in_item_t in_data;
  tpr_pkg::out_item_t out_data;
  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tpr_pkg::DEGREE_W-1:0]  cfg_data;

  triangle_pair_request_and_check_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [tpr_pkg::ID_W-1:0]  nbr_id  [tpr_pkg::MAX_NEIGHBORS];
  logic [tpr_pkg::KEY_W-1:0] nbr_key [tpr_pkg::MAX_NEIGHBORS];
  int unsigned n_entries, cur_i, cur_j, walk_i, walk_j, pend_pairs;
  logic [tpr_pkg::HITS_W-1:0] hits;
  int unsigned quota_mult, degree;

  tpr_pkg::out_item_t expected_q[$];
  row_t rows[$];
  int errors = 0;
  int idle_pct = 18;
  int quiet = 0;
  logic [tpr_pkg::KEY_W-1:0] last_key = '0;
  logic [tpr_pkg::ID_W-1:0]  last_id = '0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [tpr_pkg::ID_W-1:0] id_at(int unsigned k);
    return (k < tpr_pkg::MAX_NEIGHBORS) ? nbr_id[k] : '0;
  endfunction

  function automatic logic [tpr_pkg::KEY_W-1:0] key_at(int unsigned k);
    return (k < tpr_pkg::MAX_NEIGHBORS) ? nbr_key[k] : '0;
  endfunction

  function automatic tpr_pkg::out_item_t predict_result(tpr_pkg::in_item_t it);
    tpr_pkg::out_item_t o;
    longint unsigned q, cnt, avail;
    int unsigned i, j, lo, hi, mid;
    bit less;
    o = '0;
    case (it.action)
      tpr_pkg::ACT_LOAD: begin
        if (pend_pairs == 0) begin
          if (n_entries < tpr_pkg::MAX_NEIGHBORS) begin
            nbr_id[n_entries] = it.edge_id;
            nbr_key[n_entries] = it.edge_key;
            n_entries++;
          end else o.table_full = 1'b1;
        end
      end
      tpr_pkg::ACT_BEGIN: begin
        q = longint'(quota_mult) * degree;
        cnt = 0;
        i = cur_i;
        j = cur_j + 1;
        if (q > 0) begin
          while (i < n_entries) begin
            avail = (j < n_entries) ? n_entries - j : 0;
            if (avail >= q) begin
              j += int'(q - 1);
              cnt += q;
              break;
            end
            cnt += avail;
            q -= avail;
            j = i + 2;
            i++;
          end
          if (j > tpr_pkg::MAX_NEIGHBORS + 1) j = tpr_pkg::MAX_NEIGHBORS + 1;
          cur_i = i;
          cur_j = j;
        end
        pend_pairs = int'(cnt);
        if (cnt > 0) begin
          if (j >= n_entries) begin
            j = n_entries - 1;
            i = j - 1;
          end
          walk_i = i;
          walk_j = j;
        end else begin
          walk_i = 0;
          walk_j = 0;
        end
        o.pair_count = cnt[tpr_pkg::PAIRS_W-1:0];
        o.halted = (cnt == 0);
      end
      tpr_pkg::ACT_FETCH: begin
        if (pend_pairs != 0) begin
          o.dest_id = id_at(walk_i);
          o.pair_edge_id = id_at(walk_j);
          o.pair_edge_key = key_at(walk_j);
          pend_pairs--;
          if (pend_pairs == 0) o.last_pair = 1'b1;
          else begin
            walk_j--;
            if (walk_j <= walk_i) begin
              walk_i--;
              walk_j = n_entries - 1;
            end
          end
        end
      end
      default: begin
        lo = 0;
        hi = n_entries;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          less = (key_at(mid) < it.edge_key) ||
                 (key_at(mid) == it.edge_key && id_at(mid) < it.edge_id);
          if (less) lo = mid + 1;
          else hi = mid;
        end
        if (lo < n_entries && key_at(lo) == it.edge_key && id_at(lo) == it.edge_id) begin
          o.found = 1'b1;
          if (hits != '1) hits++;
        end
      end
    endcase
    o.triangle_count = hits;
    return o;
  endfunction

  task automatic field_check(string name, longint unsigned w, longint unsigned g);
    if (w != g) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, w, g);
    end
  endtask

  // result side: random backpressure and in-order comparison
  always @(posedge clk) begin
    tpr_pkg::out_item_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %0h", $time, out_data);
      end else begin
        w = expected_q.pop_front();
        field_check("pair_count", w.pair_count, out_data.pair_count);
        field_check("halted", w.halted, out_data.halted);
        field_check("dest_id", w.dest_id, out_data.dest_id);
        field_check("pair_edge_id", w.pair_edge_id, out_data.pair_edge_id);
        field_check("pair_edge_key", w.pair_edge_key, out_data.pair_edge_key);
        field_check("last_pair", w.last_pair, out_data.last_pair);
        field_check("found", w.found, out_data.found);
        field_check("triangle_count", w.triangle_count, out_data.triangle_count);
        field_check("table_full", w.table_full, out_data.table_full);
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(tpr_pkg::in_item_t it, bit typed = 0,
                      tpr_pkg::out_item_t want = '0);
    tpr_pkg::out_item_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    p = predict_result(it);
    expected_q = {expected_q, (typed ? want : p)};
  endtask

  // register write, only once all results are back and the block has settled
  task automatic write_reg(logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                           logic [tpr_pkg::DEGREE_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tpr_pkg::CFG_QUOTA) quota_mult = {24'd0, data[tpr_pkg::QUOTA_W-1:0]};
    else degree = {12'd0, data};
  endtask

  function automatic tpr_pkg::in_item_t sorted_load();
    tpr_pkg::in_item_t it;
    if (($urandom_range(3) == 0 || last_key == '1) && last_id < 31'h7FFF0000)
      last_id = last_id + tpr_pkg::ID_W'(1 + $urandom_range(0, 1000));
    else begin
      last_key = (int'(last_key) + 1500 > 20'hFFFFF) ? 20'hFFFFF
                 : last_key + tpr_pkg::KEY_W'($urandom_range(1, 1500));
      last_id = tpr_pkg::ID_W'($urandom());
    end
    it.action = tpr_pkg::ACT_LOAD;
    it.edge_id = last_id;
    it.edge_key = last_key;
    return it;
  endfunction

  function automatic tpr_pkg::in_item_t any_item(tpr_pkg::action_t a);
    tpr_pkg::in_item_t it;
    it.action = a;
    it.edge_id = tpr_pkg::ID_W'($urandom());
    it.edge_key = tpr_pkg::KEY_W'($urandom());
    return it;
  endfunction

  task automatic add_item(tpr_pkg::action_t a, logic [tpr_pkg::ID_W-1:0] id,
                          logic [tpr_pkg::KEY_W-1:0] key,
                          bit typed = 0, tpr_pkg::out_item_t want = '0);
    row_t r;
    r.kind = ROW_ITEM;
    r.item.action = a;
    r.item.edge_id = id;
    r.item.edge_key = key;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  task automatic add_cfg(logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                         logic [tpr_pkg::DEGREE_W-1:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    rows = {rows, r};
  endtask

  initial begin
    tpr_pkg::out_item_t w;
    tpr_pkg::in_item_t it;
    int n, k, m;
    logic [tpr_pkg::QUOTA_W-1:0] qf_list [10];
    logic [tpr_pkg::DEGREE_W-1:0] deg_list [10];

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    n_entries = 0; cur_i = 0; cur_j = 0; walk_i = 0; walk_j = 0;
    pend_pairs = 0; hits = '0;
    quota_mult = {24'd0, tpr_pkg::QUOTA_RESET};
    degree = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table with zero quota, then small rounds
    w = '0; w.halted = 1'b1;
    add_item(tpr_pkg::ACT_BEGIN, '0, '0, 1, w);
    add_item(tpr_pkg::ACT_FETCH, '1, '1, 1, '0);
    add_item(tpr_pkg::ACT_CHECK, '1, '1, 1, '0);
    add_item(tpr_pkg::ACT_LOAD, '0, '0, 1, '0);
    add_item(tpr_pkg::ACT_LOAD, 31'd7, 20'd5);
    add_item(tpr_pkg::ACT_LOAD, 31'h7FFFFFFF, 20'd5);
    add_item(tpr_pkg::ACT_LOAD, 31'd1, 20'hFFFFF);
    add_item(tpr_pkg::ACT_BEGIN, '0, '0, 1, w);
    add_cfg(tpr_pkg::CFG_QUOTA, 20'hABC01);
    add_cfg(tpr_pkg::CFG_DEGREE, 20'd3);
    add_item(tpr_pkg::ACT_BEGIN, '0, '0);
    // load inside a round is ignored
    add_item(tpr_pkg::ACT_LOAD, 31'h12345, 20'hFFFFF);
    repeat (4) add_item(tpr_pkg::ACT_FETCH, '0, '0);
    add_item(tpr_pkg::ACT_CHECK, 31'h7FFFFFFF, 20'd5);
    add_item(tpr_pkg::ACT_CHECK, 31'd7, 20'd5);
    add_item(tpr_pkg::ACT_CHECK, 31'd6, 20'd5);
    add_item(tpr_pkg::ACT_CHECK, 31'd1, 20'hFFFFF);
    add_cfg(tpr_pkg::CFG_QUOTA, 20'h000FF);
    add_cfg(tpr_pkg::CFG_DEGREE, 20'hFFFFF);
    add_item(tpr_pkg::ACT_BEGIN, '0, '0);
    repeat (4) add_item(tpr_pkg::ACT_FETCH, '0, '0);
    add_item(tpr_pkg::ACT_BEGIN, '0, '0);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) write_reg(rows[r].idx, rows[r].data);
      else send(rows[r].item, rows[r].typed, rows[r].want);
    end
    // keep the table sorted past the directed entries
    last_key = 20'hFFFFF;
    last_id = 31'd1;

    qf_list = '{8'd1, 8'd255, 8'd1, 8'd3, 8'd255, 8'd10, 8'd2, 8'd255, 8'd7, 8'd1};
    deg_list = '{20'd1, 20'hFFFFF, 20'd0, 20'd2, 20'd3, 20'd1, 20'd4, 20'd0, 20'd2, 20'd5};
    deg_list[9] = tpr_pkg::DEGREE_W'($urandom_range(1, 20));
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(tpr_pkg::CFG_QUOTA, {12'($urandom()), qf_list[ph]});
      write_reg(tpr_pkg::CFG_DEGREE, (ph == 6) ? 20'($urandom()) : deg_list[ph]);
      idle_pct = (ph == 4) ? 0 : 18;
      n = 0;
      while (n < 90) begin
        m = $urandom_range(99);
        if (m < 30) begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            if ($urandom_range(99) < 4) send(any_item(tpr_pkg::ACT_LOAD));
            else send(sorted_load());
          end
          n += k;
        end else if (m < 45) begin
          send(any_item(tpr_pkg::ACT_BEGIN));
          n++;
        end else if (m < 75) begin
          k = (pend_pairs <= 40) ? pend_pairs + $urandom_range(0, 1)
                                 : $urandom_range(1, 40);
          if (k == 0) k = 1;
          repeat (k) send(any_item(tpr_pkg::ACT_FETCH));
          n += k;
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) begin
            it = any_item(tpr_pkg::ACT_CHECK);
            if (n_entries > 0 && $urandom_range(99) < 60) begin
              m = $urandom_range(0, n_entries - 1);
              it.edge_id = nbr_id[m];
              it.edge_key = nbr_key[m];
            end
            send(it);
          end
          n += k;
        end
      end
    end

    // largest quota: walk the rest of the table, then a halted round
    idle_pct = 18;
    write_reg(tpr_pkg::CFG_QUOTA, 20'h000FF);
    write_reg(tpr_pkg::CFG_DEGREE, 20'hFFFFF);
    send(any_item(tpr_pkg::ACT_BEGIN));
    repeat (5) send(any_item(tpr_pkg::ACT_FETCH));
    send(any_item(tpr_pkg::ACT_BEGIN));
    send(any_item(tpr_pkg::ACT_FETCH));

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
